// ===== hdl/triangle_tangent_bitangent_top_defines.svh =====
// Assertion macros shared by the tangent frame block's checker.
// No dependencies.
`ifndef TRIANGLE_TANGENT_BITANGENT_TOP_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define TTB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define TTB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ttb_pkg.sv =====
// Shared types and constants for the tangent frame block.
// No dependencies.
`timescale 1ns / 1ps

package ttb_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int POS_W        = 48;
   localparam int UV_W         = 32;
   localparam int DIFF_W       = 17;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int NUM_W        = PROD_W + 1;
   localparam int RES_W        = 32;
   // Q8.8 over Q4.12 scaled to Q16.16 is a factor of 2^20
   localparam int FRAC_SHIFT   = 20;
   // quotient bits produced after the overflow check
   localparam int DIV_STEPS    = 34;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TRI  = 1'b1;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_RDB  = 9'b000000010,
      S_RDC  = 9'b000000100,
      S_CAPC = 9'b000001000,
      S_DET  = 9'b000010000,
      S_NUM  = 9'b000100000,
      S_DIVS = 9'b001000000,
      S_DIVW = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   typedef logic signed [DIFF_W-1:0] diff_type;

endpackage

// ===== hdl/ttb_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module ttb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ttb_div.sv =====
// Iterative signed divider, (num * 2^20) / den, truncated and saturated to 32 bits.
// Depends on ttb_pkg.
`timescale 1ns / 1ps

module ttb_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [ttb_pkg::NUM_W-1:0] num,
   input  logic signed [ttb_pkg::NUM_W-1:0] den,
   output logic                             done,
   output logic [ttb_pkg::RES_W-1:0]        quot
);

   localparam int NW = ttb_pkg::NUM_W;
   localparam int HI = ttb_pkg::DIV_STEPS - ttb_pkg::FRAC_SHIFT;

   logic [NW-1:0]                    num_mag;
   logic [NW-1:0]                    den_mag;
   logic [NW-1:0]                    rem_init;
   logic [NW:0]                      trial;
   logic                             fits;

   logic [NW-1:0]                    rem_ff, rem_in;
   logic [ttb_pkg::DIV_STEPS-1:0]    dvd_ff, dvd_in;
   logic [ttb_pkg::DIV_STEPS-1:0]    q_ff, q_in;
   logic [NW-1:0]                    den_ff, den_in;
   logic                             neg_ff, neg_in;
   logic                             ovf_ff, ovf_in;
   logic [ttb_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                             run_ff, run_in;
   logic                             fin_ff, fin_in;
   logic                             done_ff, done_in;
   logic [ttb_pkg::RES_W-1:0]        quot_ff, quot_in;

   // magnitudes and the initial partial remainder
   assign num_mag  = num[NW-1] ? NW'(-num) : NW'(num);
   assign den_mag  = den[NW-1] ? NW'(-den) : NW'(den);
   assign rem_init = NW'(num_mag[NW-1:HI]);

   // one restoring step
   assign trial = {rem_ff, dvd_ff[ttb_pkg::DIV_STEPS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      quot_in = quot_ff;
      if (start) begin
         rem_in = rem_init;
         dvd_in = {num_mag[HI-1:0], ttb_pkg::FRAC_SHIFT'(0)};
         q_in   = '0;
         den_in = den_mag;
         neg_in = num[NW-1] ^ den[NW-1];
         ovf_in = rem_init >= den_mag;
         cnt_in = ttb_pkg::DIV_CNT_W'(ttb_pkg::DIV_STEPS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? NW'(trial - {1'b0, den_ff}) : NW'(trial);
         dvd_in = {dvd_ff[ttb_pkg::DIV_STEPS-2:0], 1'b0};
         q_in   = {q_ff[ttb_pkg::DIV_STEPS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ttb_pkg::DIV_CNT_W'(1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      // sign and saturation
      if (fin_ff) begin
         done_in = 1'b1;
         if (!neg_ff) begin
            if (ovf_ff || q_ff > ttb_pkg::DIV_STEPS'(34'h07FFFFFFF)) begin
               quot_in = 32'h7FFFFFFF;
            end else begin
               quot_in = q_ff[ttb_pkg::RES_W-1:0];
            end
         end else begin
            if (ovf_ff || q_ff > ttb_pkg::DIV_STEPS'(34'h080000000)) begin
               quot_in = 32'h80000000;
            end else begin
               quot_in = -q_ff[ttb_pkg::RES_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hdl/triangle_tangent_bitangent_top.sv =====
// Top level of the per-triangle tangent frame block.
// Depends on ttb_pkg, ttb_ram and ttb_div.
`timescale 1ns / 1ps

// Usage
//   Input: an item is taken at a rising edge with start high and busy low.
//   req_command selects a vertex load (writes position and UV at
//   req_vertex_index) or a triangle (corners a, b, c).
//   A load keeps busy low and no result follows.
//   A triangle reads its three corners from the vertex memories (one read
//   port, one corner a cycle), forms the determinant, then runs six
//   divisions through one shared 34-step divider. Busy stays high until
//   the third result has been delivered.
//   Output: three items, corners a, b, c in order, each on the rsp_ ports
//   for exactly one cycle with rsp_strobe high; rsp_last_corner marks the
//   third. The receiver cannot stall the block.
//   A zero determinant skips the divider: rsp_degenerate is set and all
//   vector fields are zero.
//   Reset returns the controller to idle. The vertex memories are not
//   cleared; a corner must be loaded before a triangle reads it.

module triangle_tangent_bitangent_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [ttb_pkg::IDX_W-1:0]            req_vertex_index,
   input  logic signed [15:0]                   req_pos_x,
   input  logic signed [15:0]                   req_pos_y,
   input  logic signed [15:0]                   req_pos_z,
   input  logic signed [15:0]                   req_tex_u,
   input  logic signed [15:0]                   req_tex_v,
   input  logic [ttb_pkg::IDX_W-1:0]            req_corner_a,
   input  logic [ttb_pkg::IDX_W-1:0]            req_corner_b,
   input  logic [ttb_pkg::IDX_W-1:0]            req_corner_c,
   output logic                                 rsp_strobe,
   output logic [ttb_pkg::IDX_W-1:0]            rsp_target_vertex,
   output logic signed [ttb_pkg::RES_W-1:0]     rsp_tangent_x,
   output logic signed [ttb_pkg::RES_W-1:0]     rsp_tangent_y,
   output logic signed [ttb_pkg::RES_W-1:0]     rsp_tangent_z,
   output logic signed [ttb_pkg::RES_W-1:0]     rsp_bitangent_x,
   output logic signed [ttb_pkg::RES_W-1:0]     rsp_bitangent_y,
   output logic signed [ttb_pkg::RES_W-1:0]     rsp_bitangent_z,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_last_corner
);

   localparam int DW = ttb_pkg::DIFF_W;
   localparam int PW = ttb_pkg::PROD_W;
   localparam int NW = ttb_pkg::NUM_W;

   ttb_pkg::state_type                 state_ff, state_in;

   logic                               accept;
   logic                               wr_en;
   logic [ttb_pkg::IDX_W-1:0]          rd_addr;
   logic [ttb_pkg::POS_W-1:0]          pos_rd;
   logic [ttb_pkg::UV_W-1:0]           uv_rd;

   logic [ttb_pkg::IDX_W-1:0]          corner_ff [3];
   logic [ttb_pkg::IDX_W-1:0]          corner_in [3];
   logic signed [15:0]                 pa_ff [3];
   logic signed [15:0]                 pa_in [3];
   logic signed [15:0]                 ua_ff, ua_in, va_ff, va_in;
   ttb_pkg::diff_type                  e0_ff [3];
   ttb_pkg::diff_type                  e0_in [3];
   ttb_pkg::diff_type                  e1_ff [3];
   ttb_pkg::diff_type                  e1_in [3];
   ttb_pkg::diff_type                  du0_ff, du0_in, dv0_ff, dv0_in;
   ttb_pkg::diff_type                  du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [NW-1:0]               det_ff, det_in;
   logic signed [NW-1:0]               num_ff, num_in;
   logic [1:0]                         comp_ff, comp_in;
   logic                               half_ff, half_in;
   logic [1:0]                         out_ff, out_in;
   logic                               degen_ff, degen_in;
   logic [ttb_pkg::RES_W-1:0]          res_ff [6];
   logic [ttb_pkg::RES_W-1:0]          res_in [6];

   ttb_pkg::diff_type                  op_a, op_b, op_c, op_d;
   logic signed [PW-1:0]               prod_ab, prod_cd;
   logic [2:0]                         res_sel;
   logic                               div_start;
   logic                               div_done;
   logic [ttb_pkg::RES_W-1:0]          div_quot;

   assign accept = start && (state_ff == ttb_pkg::S_IDLE);
   assign wr_en  = accept && (req_command == ttb_pkg::CMD_LOAD);

   // corner read address: a at accept, then b, then c
   always_comb begin
      case (state_ff)
         ttb_pkg::S_RDB: rd_addr = corner_ff[1];
         ttb_pkg::S_RDC: rd_addr = corner_ff[2];
         default:        rd_addr = req_corner_a;
      endcase
   end

   ttb_ram #(.WIDTH(ttb_pkg::POS_W), .DEPTH(ttb_pkg::MAX_VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_vertex_index),
      .wr_data ({req_pos_z, req_pos_y, req_pos_x}),
      .rd_addr (rd_addr),
      .rd_data (pos_rd)
   );

   ttb_ram #(.WIDTH(ttb_pkg::UV_W), .DEPTH(ttb_pkg::MAX_VERTICES)) u_uv_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_vertex_index),
      .wr_data ({req_tex_v, req_tex_u}),
      .rd_addr (rd_addr),
      .rd_data (uv_rd)
   );

   // numerator operands: tangent uses e0*dv1 - e1*dv0, bitangent e1*du0 - e0*du1
   always_comb begin
      if (!half_ff) begin
         op_a = e0_ff[comp_ff];
         op_b = dv1_ff;
         op_c = e1_ff[comp_ff];
         op_d = dv0_ff;
      end else begin
         op_a = e1_ff[comp_ff];
         op_b = du0_ff;
         op_c = e0_ff[comp_ff];
         op_d = du1_ff;
      end
   end

   // shared multiplier pair: determinant in S_DET, numerators in S_NUM
   always_comb begin
      if (state_ff == ttb_pkg::S_DET) begin
         prod_ab = du0_ff * dv1_ff;
         prod_cd = dv0_ff * du1_ff;
      end else begin
         prod_ab = op_a * op_b;
         prod_cd = op_c * op_d;
      end
   end

   assign res_sel   = half_ff ? 3'(comp_ff) + 3'd3 : 3'(comp_ff);
   assign div_start = (state_ff == ttb_pkg::S_DIVS);

   ttb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (det_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      pa_in     = pa_ff;
      ua_in     = ua_ff;
      va_in     = va_ff;
      e0_in     = e0_ff;
      e1_in     = e1_ff;
      du0_in    = du0_ff;
      dv0_in    = dv0_ff;
      du1_in    = du1_ff;
      dv1_in    = dv1_ff;
      det_in    = det_ff;
      num_in    = num_ff;
      comp_in   = comp_ff;
      half_in   = half_ff;
      out_in    = out_ff;
      degen_in  = degen_ff;
      res_in    = res_ff;
      case (state_ff)
         ttb_pkg::S_IDLE: begin
            if (accept && req_command == ttb_pkg::CMD_TRI) begin
               corner_in[0] = req_corner_a;
               corner_in[1] = req_corner_b;
               corner_in[2] = req_corner_c;
               state_in     = ttb_pkg::S_RDB;
            end
         end
         ttb_pkg::S_RDB: begin
            // corner a arrives
            for (int i = 0; i < 3; i++) begin
               pa_in[i] = pos_rd[16*i +: 16];
            end
            ua_in    = uv_rd[15:0];
            va_in    = uv_rd[31:16];
            state_in = ttb_pkg::S_RDC;
         end
         ttb_pkg::S_RDC: begin
            // corner b arrives
            for (int i = 0; i < 3; i++) begin
               e0_in[i] = DW'($signed(pos_rd[16*i +: 16])) - DW'(pa_ff[i]);
            end
            du0_in   = DW'($signed(uv_rd[15:0])) - DW'(ua_ff);
            dv0_in   = DW'($signed(uv_rd[31:16])) - DW'(va_ff);
            state_in = ttb_pkg::S_CAPC;
         end
         ttb_pkg::S_CAPC: begin
            // corner c arrives
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = DW'($signed(pos_rd[16*i +: 16])) - DW'(pa_ff[i]);
            end
            du1_in   = DW'($signed(uv_rd[15:0])) - DW'(ua_ff);
            dv1_in   = DW'($signed(uv_rd[31:16])) - DW'(va_ff);
            state_in = ttb_pkg::S_DET;
         end
         ttb_pkg::S_DET: begin
            det_in   = NW'(prod_ab) - NW'(prod_cd);
            comp_in  = 2'd0;
            half_in  = 1'b0;
            out_in   = 2'd0;
            state_in = ttb_pkg::S_NUM;
         end
         ttb_pkg::S_NUM: begin
            if (det_ff == '0) begin
               degen_in = 1'b1;
               for (int i = 0; i < 6; i++) begin
                  res_in[i] = '0;
               end
               state_in = ttb_pkg::S_OUT;
            end else begin
               degen_in = 1'b0;
               num_in   = NW'(prod_ab) - NW'(prod_cd);
               state_in = ttb_pkg::S_DIVS;
            end
         end
         ttb_pkg::S_DIVS: begin
            state_in = ttb_pkg::S_DIVW;
         end
         ttb_pkg::S_DIVW: begin
            if (div_done) begin
               res_in[res_sel] = div_quot;
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  half_in  = 1'b1;
                  state_in = half_ff ? ttb_pkg::S_OUT : ttb_pkg::S_NUM;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ttb_pkg::S_NUM;
               end
            end
         end
         ttb_pkg::S_OUT: begin
            out_in = out_ff + 2'd1;
            if (out_ff == 2'd2) begin
               state_in = ttb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ttb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      corner_ff <= corner_in;
      pa_ff     <= pa_in;
      ua_ff     <= ua_in;
      va_ff     <= va_in;
      e0_ff     <= e0_in;
      e1_ff     <= e1_in;
      du0_ff    <= du0_in;
      dv0_ff    <= dv0_in;
      du1_ff    <= du1_in;
      dv1_ff    <= dv1_in;
      det_ff    <= det_in;
      num_ff    <= num_in;
      comp_ff   <= comp_in;
      half_ff   <= half_in;
      out_ff    <= out_in;
      degen_ff  <= degen_in;
      res_ff    <= res_in;
   end

   // result ports
   assign busy              = (state_ff != ttb_pkg::S_IDLE);
   assign rsp_strobe        = (state_ff == ttb_pkg::S_OUT);
   assign rsp_target_vertex = corner_ff[out_ff];
   assign rsp_tangent_x     = res_ff[0];
   assign rsp_tangent_y     = res_ff[1];
   assign rsp_tangent_z     = res_ff[2];
   assign rsp_bitangent_x   = res_ff[3];
   assign rsp_bitangent_y   = res_ff[4];
   assign rsp_bitangent_z   = res_ff[5];
   assign rsp_degenerate    = degen_ff;
   assign rsp_last_corner   = rsp_strobe && (out_ff == 2'd2);

endmodule

// ===== hdl/ttb_chk.sv =====
// Port-level checks for the tangent frame block, bound to the top level.
// Depends on ttb_pkg and triangle_tangent_bitangent_top_defines.svh.
`timescale 1ns / 1ps
`include "triangle_tangent_bitangent_top_defines.svh"

module ttb_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_command,
   input logic                             rsp_strobe,
   input logic signed [ttb_pkg::RES_W-1:0] rsp_tangent_x,
   input logic signed [ttb_pkg::RES_W-1:0] rsp_bitangent_z,
   input logic                             rsp_degenerate,
   input logic                             rsp_last_corner
);

   // results appear only inside a triangle's busy window
   `TTB_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_strobe, busy, "result while idle")

   // the last-corner flag marks a delivered item
   `TTB_ASSERT_NOW(a_last_strobe, clock, reset, rsp_last_corner, rsp_strobe, "stray last flag")

   // the three corners of a triangle come back to back
   `TTB_ASSERT_NXT(a_corner_run, clock, reset, rsp_strobe && !rsp_last_corner, rsp_strobe,
      "corner gap")

   // a degenerate frame carries zero in tangent x and bitangent z
   `TTB_ASSERT_NOW(a_degen_zero, clock, reset, rsp_strobe && rsp_degenerate,
      rsp_tangent_x == 0 && rsp_bitangent_z == 0, "degenerate frame not zero")

   // a triangle keeps the block busy
   `TTB_ASSERT_NXT(a_tri_busy, clock, reset,
      start && !busy && req_command == ttb_pkg::CMD_TRI, busy, "triangle not taken")

endmodule

bind triangle_tangent_bitangent_top ttb_chk u_ttb_chk (.*);
